>>> rtl/tovg_pkg.sv
// Package for the text overlay pixel generator: payload words, command and
// register codes, reset values and the 5x7 font table.
// Depends on nothing; used by every other file of the block.
`default_nettype none

package tovg_pkg;

  // Widths of the payload fields.
  localparam int PIXEL_X_W = 10;
  localparam int PIXEL_Y_W = 8;

  // Glyph and cell geometry in font pixels.
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int CELL_COLS  = 6;
  localparam int CELL_ROWS  = 8;

  localparam logic [7:0] SPACE_CODE = 8'h20;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FG_RED      = 3'd0;
  localparam logic [2:0] CFG_FG_GREEN    = 3'd1;
  localparam logic [2:0] CFG_FG_BLUE     = 3'd2;
  localparam logic [2:0] CFG_FG_ALPHA    = 3'd3;
  localparam logic [2:0] CFG_BG_ALPHA    = 3'd4;
  localparam logic [2:0] CFG_MARGIN_LEFT = 3'd5;
  localparam logic [2:0] CFG_MARGIN_TOP  = 3'd6;

  // Configuration reset values.
  localparam logic [7:0] RST_FG_RED      = 8'd80;
  localparam logic [7:0] RST_FG_GREEN    = 8'd255;
  localparam logic [7:0] RST_FG_BLUE     = 8'd160;
  localparam logic [7:0] RST_FG_ALPHA    = 8'd255;
  localparam logic [7:0] RST_BG_ALPHA    = 8'd150;
  localparam logic [7:0] RST_MARGIN_LEFT = 8'd8;
  localparam logic [7:0] RST_MARGIN_TOP  = 8'd8;

  typedef struct packed {
    logic [1:0]           command;
    logic [2:0]           line_index;
    logic [4:0]           column_index;
    logic [7:0]           char_code;
    logic [PIXEL_X_W-1:0] pixel_x;
    logic [PIXEL_Y_W-1:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_word_t;

  // Operation presented to the character store in one cycle.
  typedef struct packed {
    logic wr;
    logic clr;
    logic rd;
  } store_req_t;

  // One pixel of the font. Rows are packed top row first; within a row the
  // leftmost glyph column is the most significant bit.
  function automatic logic font_pixel(input logic [7:0] code, input logic [2:0] gx,
                                      input logic [2:0] gy);
    logic [GLYPH_COLS*GLYPH_ROWS-1:0] bits;
    int idx;
    case (code)
      8'h30: bits = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      8'h31: bits = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h32: bits = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      8'h33: bits = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      8'h34: bits = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      8'h35: bits = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      8'h36: bits = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      8'h37: bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38: bits = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      8'h39: bits = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      8'h2E: bits = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
      8'h25: bits = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
      8'h2D: bits = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      8'h61: bits = {5'h00, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F};
      8'h62: bits = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
      8'h63: bits = {5'h00, 5'h00, 5'h0F, 5'h10, 5'h10, 5'h10, 5'h0F};
      8'h64: bits = {5'h01, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h11, 5'h0F};
      8'h65: bits = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0F};
      8'h69: bits = {5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h6B: bits = {5'h10, 5'h10, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12};
      8'h6C: bits = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h6D: bits = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h15, 5'h15};
      8'h6F: bits = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h70: bits = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
      8'h72: bits = {5'h00, 5'h00, 5'h17, 5'h18, 5'h10, 5'h10, 5'h10};
      8'h73: bits = {5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E};
      8'h74: bits = {5'h08, 5'h08, 5'h1F, 5'h08, 5'h08, 5'h09, 5'h06};
      default: bits = '0;
    endcase
    if (gx >= 3'(GLYPH_COLS) || gy >= 3'(GLYPH_ROWS)) begin
      return 1'b0;
    end
    idx = GLYPH_COLS * GLYPH_ROWS - 1 - GLYPH_COLS * int'(gy) - int'(gx);
    return bits[6'(idx)];
  endfunction

endpackage

`default_nettype wire

>>> rtl/tovg_cell_store.sv
// Character cell store of the text overlay generator: one synchronous RAM of
// codes plus a valid bit per cell, so that reset and clear act on every cell at once.
// Depends on tovg_pkg for the request struct and the blank code.
`default_nettype none

module tovg_cell_store #(
  parameter int unsigned DEPTH = 192
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tovg_pkg::store_req_t       req_i,
  input  wire logic [$clog2(DEPTH)-1:0]   addr_i,
  input  wire logic [7:0]                 wdata_i,
  output logic [7:0]                      code_o
);

  logic [7:0]       mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [7:0]       rd_data_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (req_i.rd) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (req_i.rd) begin
        rd_valid_q <= valid_q[addr_i];
      end
    end
  end

  // A cell never written since reset or the last clear reads as a space.
  assign code_o = rd_valid_q ? rd_data_q : tovg_pkg::SPACE_CODE;

`ifndef ASSERT_OFF
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({req_i.wr, req_i.clr, req_i.rd}))
    else $error("store given more than one operation in a cycle");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.clr |=> (valid_q == '0))
    else $error("cells still marked valid after a clear");

  a_write_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr |=> valid_q[$past(addr_i)])
    else $error("written cell not marked valid");
`endif

endmodule

`default_nettype wire

>>> rtl/text_overlay_pixel_generator.sv
// A query's result word is presented from the output register after stage 5;
// writes and clears act on the store in stage 4 and leave the pipe there.
// Throughput: one word per clock, set by the single port of the cell store,
// which takes one read, write or clear each cycle; stalls only back up the pipe.
// Reset: colour and margin registers return to their defaults, and every cell
// reads as a space at once because its valid bit is cleared; no clearing pass.
// Top level of the text overlay pixel generator: a five-stage pipeline around
// the character cell store. Depends on tovg_pkg and tovg_cell_store.
`default_nettype none

module text_overlay_pixel_generator #(
  parameter int FRAME_WIDTH  = 768,
  parameter int FRAME_HEIGHT = 192,
  parameter int FONT_SCALE   = 4,
  parameter int TEXT_LINES   = 6,
  parameter int LINE_CHARS   = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Item input
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tovg_pkg::in_word_t  in_word_i,
  // Result output
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tovg_pkg::out_word_t      out_word_o,
  // Configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i
);

  // Cell pitch in frame pixels.
  localparam int CELL_W = tovg_pkg::CELL_COLS * FONT_SCALE;
  localparam int CELL_H = tovg_pkg::CELL_ROWS * FONT_SCALE;

  // The top-down row fits in TYW bits; YCW also holds a margin value.
  localparam int TYW = $clog2(FRAME_HEIGHT);
  localparam int YCW = (TYW > 8) ? TYW : 8;
  localparam int DXW = tovg_pkg::PIXEL_X_W;
  localparam int DYW = TYW;

  // Division by the cell pitch is a multiply by a truncated reciprocal. The
  // estimate is the true quotient or one less, and one correction step fixes it.
  localparam int DIV_SH  = 16;
  localparam int RECIP_X = (1 << DIV_SH) / CELL_W;
  localparam int RECIP_Y = (1 << DIV_SH) / CELL_H;
  localparam int PW      = DIV_SH + 12;
  localparam int QXW     = $clog2((2 ** DXW - 1) / CELL_W + 2);
  localparam int QYW     = $clog2((2 ** DYW - 1) / CELL_H + 2);
  localparam int RXW     = $clog2(CELL_W);
  localparam int RYW     = $clog2(CELL_H);

  // Only cells that the write fields can address are stored; all others stay
  // blank for good.
  localparam int ELN        = (TEXT_LINES < 8) ? TEXT_LINES : 8;
  localparam int ECH        = (LINE_CHARS < 32) ? LINE_CHARS : 32;
  localparam int CAW        = (ECH > 1) ? $clog2(ECH) : 1;
  localparam int CELL_DEPTH = ELN * (2 ** CAW);
  localparam int AW         = $clog2(CELL_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers. The port is always ready; an index beyond the
  // register list is accepted and dropped.
  // ---------------------------------------------------------------------------
  logic [7:0] fg_red_q, fg_green_q, fg_blue_q, fg_alpha_q, bg_alpha_q;
  logic [7:0] margin_left_q, margin_top_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_red_q      <= tovg_pkg::RST_FG_RED;
      fg_green_q    <= tovg_pkg::RST_FG_GREEN;
      fg_blue_q     <= tovg_pkg::RST_FG_BLUE;
      fg_alpha_q    <= tovg_pkg::RST_FG_ALPHA;
      bg_alpha_q    <= tovg_pkg::RST_BG_ALPHA;
      margin_left_q <= tovg_pkg::RST_MARGIN_LEFT;
      margin_top_q  <= tovg_pkg::RST_MARGIN_TOP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tovg_pkg::CFG_FG_RED:      fg_red_q      <= cfg_data_i;
        tovg_pkg::CFG_FG_GREEN:    fg_green_q    <= cfg_data_i;
        tovg_pkg::CFG_FG_BLUE:     fg_blue_q     <= cfg_data_i;
        tovg_pkg::CFG_FG_ALPHA:    fg_alpha_q    <= cfg_data_i;
        tovg_pkg::CFG_BG_ALPHA:    bg_alpha_q    <= cfg_data_i;
        tovg_pkg::CFG_MARGIN_LEFT: margin_left_q <= cfg_data_i;
        tovg_pkg::CFG_MARGIN_TOP:  margin_top_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow. Every stage moves when the one after it is free. Write and
  // clear words leave the pipe at stage 4, where they act on the store, so
  // they never wait on the output side. Only queries go on to stage 5.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic free1, free2, free3, free4, free5, take5, move4;

  tovg_pkg::cmd_e cmd1_q, cmd2_q, cmd3_q, cmd4_q;
  logic [2:0]     wl1_q, wl2_q, wl3_q, wl4_q;
  logic [4:0]     wc1_q, wc2_q, wc3_q, wc4_q;
  logic [7:0]     code1_q, code2_q, code3_q, code4_q;

  assign take5 = !vo_q || !out_stall_i;
  assign free5 = !v5_q || take5;
  assign move4 = v4_q && ((cmd4_q != tovg_pkg::CMD_QUERY) || free5);
  assign free4 = !v4_q || move4;
  assign free3 = !v3_q || free4;
  assign free2 = !v2_q || free3;
  assign free1 = !v1_q || free2;

  assign in_stall_o = !free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (free1) begin
        v1_q <= in_valid_i;
      end
      if (free2) begin
        v2_q <= v1_q;
      end
      if (free3) begin
        v3_q <= v2_q;
      end
      if (free4) begin
        v4_q <= v3_q;
      end
      if (free5) begin
        v5_q <= v4_q && (cmd4_q == tovg_pkg::CMD_QUERY);
      end
      if (take5) begin
        vo_q <= v5_q;
      end
    end
  end

  // The write fields ride along with every word up to the store.
  always_ff @(posedge clk_i) begin
    if (free1) begin
      cmd1_q  <= tovg_pkg::cmd_e'(in_word_i.command);
      wl1_q   <= in_word_i.line_index;
      wc1_q   <= in_word_i.column_index;
      code1_q <= in_word_i.char_code;
    end
    if (free2) begin
      cmd2_q  <= cmd1_q;
      wl2_q   <= wl1_q;
      wc2_q   <= wc1_q;
      code2_q <= code1_q;
    end
    if (free3) begin
      cmd3_q  <= cmd2_q;
      wl3_q   <= wl2_q;
      wc3_q   <= wc2_q;
      code3_q <= code2_q;
    end
    if (free4) begin
      cmd4_q  <= cmd3_q;
      wl4_q   <= wl3_q;
      wc4_q   <= wc3_q;
      code4_q <= code3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: frame check, flip the row to top-down order and strip the margins.
  // A pixel outside the frame or inside a margin is marked blank here.
  // ---------------------------------------------------------------------------
  logic [DXW-1:0]                 px1_q;
  logic [tovg_pkg::PIXEL_Y_W-1:0] py1_q;
  logic                           in_frame1, left_ok1, top_ok1;
  logic [YCW-1:0]                 ty1, dy1_wide;
  logic [DXW-1:0]                 dx1;

  always_ff @(posedge clk_i) begin
    if (free1) begin
      px1_q <= in_word_i.pixel_x;
      py1_q <= in_word_i.pixel_y;
    end
  end

  always_comb begin
    in_frame1 = (32'(px1_q) < FRAME_WIDTH) && (32'(py1_q) < FRAME_HEIGHT);
    ty1       = YCW'(FRAME_HEIGHT - 1) - YCW'(py1_q);
    left_ok1  = px1_q >= DXW'(margin_left_q);
    top_ok1   = ty1 >= YCW'(margin_top_q);
    dx1       = px1_q - DXW'(margin_left_q);
    dy1_wide  = ty1 - YCW'(margin_top_q);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: reciprocal multiplies give the quotient estimates.
  // ---------------------------------------------------------------------------
  logic [DXW-1:0] dx2_q;
  logic [DYW-1:0] dy2_q;
  logic           blank2_q;
  logic [PW-1:0]  prod_x2, prod_y2;
  logic [QXW-1:0] qx2;
  logic [QYW-1:0] qy2;

  always_ff @(posedge clk_i) begin
    if (free2) begin
      dx2_q    <= dx1;
      dy2_q    <= DYW'(dy1_wide);
      blank2_q <= !(in_frame1 && left_ok1 && top_ok1);
    end
  end

  always_comb begin
    prod_x2 = PW'(dx2_q) * PW'(RECIP_X);
    prod_y2 = PW'(dy2_q) * PW'(RECIP_Y);
    qx2     = QXW'(prod_x2 >> DIV_SH);
    qy2     = QYW'(prod_y2 >> DIV_SH);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: remainder and one correction step give the cell column, text line
  // and the offset inside the cell.
  // ---------------------------------------------------------------------------
  logic [DXW-1:0] dx3_q, rx_raw3;
  logic [DYW-1:0] dy3_q, ry_raw3;
  logic [QXW-1:0] qx3_q;
  logic [QYW-1:0] qy3_q;
  logic           blank3_q, fix_x3, fix_y3;

  always_ff @(posedge clk_i) begin
    if (free3) begin
      dx3_q    <= dx2_q;
      dy3_q    <= dy2_q;
      qx3_q    <= qx2;
      qy3_q    <= qy2;
      blank3_q <= blank2_q;
    end
  end

  always_comb begin
    rx_raw3 = dx3_q - (DXW'(qx3_q) * DXW'(CELL_W));
    ry_raw3 = dy3_q - (DYW'(qy3_q) * DYW'(CELL_H));
    fix_x3  = 32'(rx_raw3) >= CELL_W;
    fix_y3  = 32'(ry_raw3) >= CELL_H;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: glyph column and row by comparing the cell offset against
  // multiples of the scale, then the store access. A query reads here; a
  // write or clear acts here and leaves the pipe.
  // ---------------------------------------------------------------------------
  logic [QXW-1:0] col4_q;
  logic [QYW-1:0] line4_q;
  logic [RXW-1:0] rx4_q;
  logic [RYW-1:0] ry4_q;
  logic           blank4_q;
  logic [2:0]     gx4, gy4;
  logic           show4, wr_ok4;
  logic [AW-1:0]  addr4;
  tovg_pkg::store_req_t store_req;
  logic [7:0]     code5;

  always_ff @(posedge clk_i) begin
    if (free4) begin
      col4_q   <= fix_x3 ? QXW'(qx3_q + 1'b1) : qx3_q;
      line4_q  <= fix_y3 ? QYW'(qy3_q + 1'b1) : qy3_q;
      rx4_q    <= fix_x3 ? RXW'(rx_raw3 - DXW'(CELL_W)) : RXW'(rx_raw3);
      ry4_q    <= fix_y3 ? RYW'(ry_raw3 - DYW'(CELL_H)) : RYW'(ry_raw3);
      blank4_q <= blank3_q;
    end
  end

  always_comb begin
    gx4 = '0;
    gy4 = '0;
    for (int k = 1; k <= tovg_pkg::GLYPH_COLS; k++) begin
      if (32'(rx4_q) >= k * FONT_SCALE) begin
        gx4 = gx4 + 3'd1;
      end
    end
    for (int k = 1; k <= tovg_pkg::GLYPH_ROWS; k++) begin
      if (32'(ry4_q) >= k * FONT_SCALE) begin
        gy4 = gy4 + 3'd1;
      end
    end
    // Off the last line or column, or in the spacing column or row of a cell,
    // the pixel is background whatever the code.
    show4 = !blank4_q && (32'(line4_q) < ELN) && (32'(col4_q) < ECH) &&
            (gx4 != 3'(tovg_pkg::GLYPH_COLS)) && (gy4 != 3'(tovg_pkg::GLYPH_ROWS));
    wr_ok4 = (32'(wl4_q) < TEXT_LINES) && (32'(wc4_q) < LINE_CHARS);

    if (cmd4_q == tovg_pkg::CMD_WRITE) begin
      addr4 = AW'((32'(wl4_q) << CAW) | 32'(wc4_q));
    end else begin
      addr4 = AW'((32'(line4_q) << CAW) | 32'(col4_q));
    end

    store_req.wr  = move4 && (cmd4_q == tovg_pkg::CMD_WRITE) && wr_ok4;
    store_req.clr = move4 && (cmd4_q == tovg_pkg::CMD_CLEAR);
    store_req.rd  = move4 && (cmd4_q == tovg_pkg::CMD_QUERY);
  end

  tovg_cell_store #(
    .DEPTH(CELL_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .addr_i (addr4),
    .wdata_i(code4_q),
    .code_o (code5)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: font lookup on the code read from the store, colour selection and
  // the output register.
  // ---------------------------------------------------------------------------
  logic [2:0]          gx5_q, gy5_q;
  logic                show5_q, lit5;
  tovg_pkg::out_word_t out_q;

  always_ff @(posedge clk_i) begin
    if (free5) begin
      gx5_q   <= gx4;
      gy5_q   <= gy4;
      show5_q <= show4;
    end
  end

  assign lit5 = show5_q && tovg_pkg::font_pixel(code5, gx5_q, gy5_q);

  always_ff @(posedge clk_i) begin
    if (take5) begin
      if (lit5) begin
        out_q.red   <= fg_red_q;
        out_q.green <= fg_green_q;
        out_q.blue  <= fg_blue_q;
        out_q.alpha <= fg_alpha_q;
      end else begin
        out_q.red   <= '0;
        out_q.green <= '0;
        out_q.blue  <= '0;
        out_q.alpha <= bg_alpha_q;
      end
    end
  end

  assign out_valid_o = vo_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  a_rem_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (32'(rx4_q) < CELL_W))
    else $error("column remainder not below the cell width");

  a_rem_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (32'(ry4_q) < CELL_H))
    else $error("row remainder not below the cell height");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1_q && !v2_q && !v3_q && !v4_q && !v5_q && !vo_q) |-> !in_stall_o)
    else $error("input stalled while the pipeline is empty");
`endif

endmodule

`default_nettype wire

>>> tb/tb_text_overlay_pixel_generator.sv
// Self-checking testbench for the text overlay pixel generator: drives cell writes,
// clears and pixel queries and compares every result word with its own prediction.
// Depends on tovg_pkg and the text_overlay_pixel_generator RTL.
`default_nettype none

module tb_text_overlay_pixel_generator;
  import tovg_pkg::*;

  // Geometry of the block as instantiated with its default parameters.
  localparam int FRAME_W   = 768;
  localparam int FRAME_H   = 192;
  localparam int SCALE     = 4;
  localparam int LINES     = 6;
  localparam int COLS      = 32;
  localparam int X_PITCH   = CELL_COLS * SCALE;
  localparam int Y_PITCH   = CELL_ROWS * SCALE;
  localparam int MAX_SHOWN = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // Shadow copy of the block's state: the cell store and the seven registers.
  logic [7:0] cell_codes [LINES*COLS];
  logic [7:0] fg_red = RST_FG_RED;
  logic [7:0] fg_green = RST_FG_GREEN;
  logic [7:0] fg_blue = RST_FG_BLUE;
  logic [7:0] fg_alpha = RST_FG_ALPHA;
  logic [7:0] bg_alpha = RST_BG_ALPHA;
  logic [7:0] margin_left = RST_MARGIN_LEFT;
  logic [7:0] margin_top = RST_MARGIN_TOP;

  out_word_t expected_pixels [$];
  int        mismatches = 0;

  // Idling controls shared between the test tasks and the two handshake sides.
  bit sender_idle_on = 1'b1;
  bit receiver_idle_on = 1'b1;
  int hold_request = 0;
  int hold_left = 0;

  text_overlay_pixel_generator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Safety net: a hung handshake or a result that never arrives ends up here.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    foreach (cell_codes[i]) begin
      cell_codes[i] = SPACE_CODE;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // One row of the 5x7 font, leftmost glyph column in bit 4. Codes without a
  // glyph, the space among them, come back as an empty row.
  function automatic logic [4:0] glyph_row(input logic [7:0] code, input int row);
    logic [55:0] rows;
    case (code)
      "0": rows = {8'h0E, 8'h11, 8'h13, 8'h15, 8'h19, 8'h11, 8'h0E};
      "1": rows = {8'h04, 8'h0C, 8'h04, 8'h04, 8'h04, 8'h04, 8'h0E};
      "2": rows = {8'h0E, 8'h11, 8'h01, 8'h02, 8'h04, 8'h08, 8'h1F};
      "3": rows = {8'h1F, 8'h02, 8'h04, 8'h02, 8'h01, 8'h11, 8'h0E};
      "4": rows = {8'h02, 8'h06, 8'h0A, 8'h12, 8'h1F, 8'h02, 8'h02};
      "5": rows = {8'h1F, 8'h10, 8'h1E, 8'h01, 8'h01, 8'h11, 8'h0E};
      "6": rows = {8'h0E, 8'h10, 8'h10, 8'h1E, 8'h11, 8'h11, 8'h0E};
      "7": rows = {8'h1F, 8'h01, 8'h02, 8'h04, 8'h08, 8'h08, 8'h08};
      "8": rows = {8'h0E, 8'h11, 8'h11, 8'h0E, 8'h11, 8'h11, 8'h0E};
      "9": rows = {8'h0E, 8'h11, 8'h11, 8'h0F, 8'h01, 8'h01, 8'h0E};
      ".": rows = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0C, 8'h0C};
      "%": rows = {8'h19, 8'h19, 8'h02, 8'h04, 8'h08, 8'h13, 8'h13};
      "-": rows = {8'h00, 8'h00, 8'h00, 8'h1F, 8'h00, 8'h00, 8'h00};
      "a": rows = {8'h00, 8'h00, 8'h0E, 8'h01, 8'h0F, 8'h11, 8'h0F};
      "b": rows = {8'h10, 8'h10, 8'h1E, 8'h11, 8'h11, 8'h11, 8'h1E};
      "c": rows = {8'h00, 8'h00, 8'h0F, 8'h10, 8'h10, 8'h10, 8'h0F};
      "d": rows = {8'h01, 8'h01, 8'h0F, 8'h11, 8'h11, 8'h11, 8'h0F};
      "e": rows = {8'h00, 8'h00, 8'h0E, 8'h11, 8'h1F, 8'h10, 8'h0F};
      "i": rows = {8'h04, 8'h00, 8'h0C, 8'h04, 8'h04, 8'h04, 8'h0E};
      "k": rows = {8'h10, 8'h10, 8'h12, 8'h14, 8'h18, 8'h14, 8'h12};
      "l": rows = {8'h0C, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h0E};
      "m": rows = {8'h00, 8'h00, 8'h1A, 8'h15, 8'h15, 8'h15, 8'h15};
      "o": rows = {8'h00, 8'h00, 8'h0E, 8'h11, 8'h11, 8'h11, 8'h0E};
      "p": rows = {8'h00, 8'h00, 8'h1E, 8'h11, 8'h1E, 8'h10, 8'h10};
      "r": rows = {8'h00, 8'h00, 8'h17, 8'h18, 8'h10, 8'h10, 8'h10};
      "s": rows = {8'h00, 8'h00, 8'h0F, 8'h10, 8'h0E, 8'h01, 8'h1E};
      "t": rows = {8'h08, 8'h08, 8'h1F, 8'h08, 8'h08, 8'h09, 8'h06};
      default: rows = '0;
    endcase
    return rows[8*(GLYPH_ROWS-1-row) +: 5];
  endfunction

  // Whether the buffer pixel (px, py), origin bottom-left, shows a lit font
  // pixel under the current margins and cell contents.
  function automatic bit pixel_lit(input int px, input int py);
    int ty, dx, dy, col, line, gx, gy;
    logic [4:0] bits;
    if (px >= FRAME_W || py >= FRAME_H) return 1'b0;
    ty = FRAME_H - 1 - py;
    if (px < int'(margin_left) || ty < int'(margin_top)) return 1'b0;
    dx = px - int'(margin_left);
    dy = ty - int'(margin_top);
    col = dx / X_PITCH;
    line = dy / Y_PITCH;
    // Past the last column or line of the store: nothing is drawn there.
    if (col >= COLS || line >= LINES) return 1'b0;
    gx = (dx % X_PITCH) / SCALE;
    gy = (dy % Y_PITCH) / SCALE;
    // The sixth column and eighth row of each cell are spacing.
    if (gx >= GLYPH_COLS || gy >= GLYPH_ROWS) return 1'b0;
    bits = glyph_row(cell_codes[line*COLS + col], gy);
    return bits[GLYPH_COLS-1-gx];
  endfunction

  // Applies one accepted word to the shadow state and queues the pixel that a
  // query must return. Writes, clears and the unused command return nothing.
  function automatic void apply_word(input in_word_t w);
    out_word_t pix;
    case (w.command)
      CMD_WRITE: begin
        if (int'(w.line_index) < LINES && int'(w.column_index) < COLS) begin
          cell_codes[int'(w.line_index)*COLS + int'(w.column_index)] = w.char_code;
        end
      end
      CMD_CLEAR: begin
        foreach (cell_codes[i]) begin
          cell_codes[i] = SPACE_CODE;
        end
      end
      CMD_QUERY: begin
        if (pixel_lit(int'(w.pixel_x), int'(w.pixel_y))) begin
          pix = '{fg_red, fg_green, fg_blue, fg_alpha};
        end else begin
          pix = '{8'd0, 8'd0, 8'd0, bg_alpha};
        end
        expected_pixels.push_back(pix);
      end
      default: ;
    endcase
  endfunction

  // Every word accepted at this edge goes through the prediction. Both signals
  // were driven by nonblocking assignments, so this sees the values of the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      apply_word(in_word);
    end
  end

  // Result checker: each accepted result word is matched against the oldest
  // prediction still waiting.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("%0t: result word with none expected: r=%0d g=%0d b=%0d a=%0d", $realtime,
                   out_word.red, out_word.green, out_word.blue, out_word.alpha);
        end
      end else begin
        want = expected_pixels.pop_front();
        if (out_word.red !== want.red || out_word.green !== want.green ||
            out_word.blue !== want.blue || out_word.alpha !== want.alpha) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("%0t: pixel expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                     $realtime, want.red, want.green, want.blue, want.alpha,
                     out_word.red, out_word.green, out_word.blue, out_word.alpha);
          end
        end
      end
    end
  end

  // Receiving side: a requested hold-off stalls for as many cycles as were requested;
  // otherwise, while idling is on, the stall comes at random with a 13 percent chance.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_idle_on && ($urandom_range(99) < 13);
    end
  end

  // ---------------------------------------------------------------------------
  // Word construction
  // ---------------------------------------------------------------------------

  // A word with every field at random; the helpers below overwrite the fields
  // that matter, so the ignored fields always carry noise.
  function automatic in_word_t random_fields();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t write_cell(input int line, input int col,
                                          input logic [7:0] code);
    in_word_t w;
    w = random_fields();
    w.command = CMD_WRITE;
    w.line_index = 3'(line);
    w.column_index = 5'(col);
    w.char_code = code;
    return w;
  endfunction

  function automatic in_word_t command_word(input cmd_e cmd);
    in_word_t w;
    w = random_fields();
    w.command = cmd;
    return w;
  endfunction

  function automatic in_word_t query_at(input int px, input int py);
    in_word_t w;
    w = command_word(CMD_QUERY);
    w.pixel_x = PIXEL_X_W'(px);
    w.pixel_y = PIXEL_Y_W'(py);
    return w;
  endfunction

  // A query landing on glyph pixel (gx, gy) of the given cell, at a random spot
  // inside the scaled font pixel. Where the cell lies below the frame, the row
  // is drawn at random instead.
  function automatic in_word_t glyph_query(input int line, input int col,
                                           input int gx, input int gy);
    int px, ty;
    px = int'(margin_left) + col*X_PITCH + gx*SCALE + $urandom_range(SCALE-1);
    ty = int'(margin_top) + line*Y_PITCH + gy*SCALE + $urandom_range(SCALE-1);
    return query_at(px, (ty < FRAME_H) ? FRAME_H - 1 - ty : $urandom_range(255));
  endfunction

  // Mostly codes that have a glyph, so that queries find lit pixels.
  function automatic logic [7:0] pick_code();
    string glyph_set;
    glyph_set = "0123456789.%-abcdeiklmoprst";
    if ($urandom_range(99) < 80) return glyph_set[$urandom_range(glyph_set.len()-1)];
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Margins stay small most of the time so that the text area fits the frame.
  function automatic logic [7:0] pick_margin();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 8'd255;
    if (roll < 3) return 8'd0;
    return 8'($urandom_range(40));
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake tasks
  // ---------------------------------------------------------------------------

  // Offers one word, after a random gap, and returns at the edge that takes it.
  // Valid stays high into the next word when there is no gap.
  task automatic send_word(input in_word_t w);
    while (sender_idle_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops sending, waits for every predicted result word, then lets the last
  // writes and clears work their way through the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    // The word taken at the edge just passed may not be in the queue yet.
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes all seven registers in turn. Only called with the block idle.
  task automatic load_regs(input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue, input logic [7:0] fga,
                           input logic [7:0] bga, input logic [7:0] left,
                           input logic [7:0] top);
    logic [7:0] values [7];
    logic [2:0] indexes [7];
    values = '{red, green, blue, fga, bga, left, top};
    indexes = '{CFG_FG_RED, CFG_FG_GREEN, CFG_FG_BLUE, CFG_FG_ALPHA, CFG_BG_ALPHA,
                CFG_MARGIN_LEFT, CFG_MARGIN_TOP};
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= indexes[i];
      cfg_data <= values[i];
      do @(posedge clk); while (!cfg_ready);
      case (indexes[i])
        CFG_FG_RED:      fg_red = values[i];
        CFG_FG_GREEN:    fg_green = values[i];
        CFG_FG_BLUE:     fg_blue = values[i];
        CFG_FG_ALPHA:    fg_alpha = values[i];
        CFG_BG_ALPHA:    bg_alpha = values[i];
        CFG_MARGIN_LEFT: margin_left = values[i];
        CFG_MARGIN_TOP:  margin_top = values[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Fills part of the store with text, then mixes writes, the odd clear, noise
  // words and queries. Most queries aim at glyph pixels of a real cell.
  task automatic run_phase(input int n_fill, input int n_mixed);
    int roll, line;
    repeat (n_fill) begin
      send_word(write_cell($urandom_range(LINES-1), $urandom_range(COLS-1), pick_code()));
    end
    repeat (n_mixed) begin
      roll = $urandom_range(99);
      if (roll < 22) begin
        // One write in ten may address a line beyond the store.
        line = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(LINES-1);
        send_word(write_cell(line, $urandom_range(COLS-1), pick_code()));
      end else if (roll < 23) begin
        send_word(command_word(CMD_CLEAR));
      end else if (roll < 25) begin
        send_word(random_fields());
      end else if (roll < 78) begin
        send_word(glyph_query($urandom_range(LINES-1), $urandom_range(COLS-1),
                              $urandom_range(CELL_COLS-1), $urandom_range(CELL_ROWS-1)));
      end else begin
        send_word(query_at($urandom_range(1023), $urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset colours and margins with a blank store, then the special cases one
  // at a time: glyph and spacing pixels, the last cell, a code without a glyph,
  // writes beyond the store, pixels outside the frame, the unused command and
  // a clear.
  task automatic test_directed_cases();
    send_word(query_at(0, 0));
    send_word(query_at(FRAME_W - 1, FRAME_H - 1));
    send_word(glyph_query(0, 0, 1, 0));
    send_word(write_cell(0, 0, "8"));
    send_word(write_cell(LINES - 1, COLS - 1, "m"));
    send_word(write_cell(1, 0, 8'hFF));
    send_word(write_cell(6, 3, "8"));
    send_word(write_cell(7, 31, "0"));
    send_word(glyph_query(0, 0, 1, 0));
    send_word(glyph_query(0, 0, 0, 0));
    send_word(glyph_query(0, 0, 5, 2));
    send_word(glyph_query(0, 0, 2, 7));
    send_word(glyph_query(LINES - 1, COLS - 1, 0, 2));
    send_word(glyph_query(1, 0, 2, 3));
    send_word(query_at(1023, 255));
    send_word(query_at(FRAME_W, 100));
    send_word(query_at(100, FRAME_H));
    send_word(query_at(3, 100));
    send_word(command_word(CMD_NONE));
    send_word(command_word(CMD_CLEAR));
    send_word(glyph_query(0, 0, 1, 0));
    send_word(glyph_query(LINES - 1, COLS - 1, 0, 2));
    drain();
  endtask

  // Colour and margin registers at their extremes. With both margins at zero
  // the text area covers the frame exactly; at 255 the right-hand cells are
  // clipped and no text line is visible.
  task automatic test_register_extremes();
    load_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    run_phase(40, 60);
    drain();
    load_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    run_phase(10, 60);
    drain();
  endtask

  // The receiver holds off for a long stretch while queries keep coming, so
  // the pipeline fills and the input stalls; then the sender waits for every
  // outstanding result.
  task automatic test_backpressure();
    load_regs(8'd17, 8'd200, 8'd99, 8'd240, 8'd60, 8'd4, 8'd12);
    run_phase(40, 0);
    hold_request = 300;
    repeat (60) begin
      send_word(glyph_query($urandom_range(LINES-1), $urandom_range(COLS-1),
                            $urandom_range(CELL_COLS-1), $urandom_range(CELL_ROWS-1)));
    end
    drain();
  endtask

  // Random traffic over several random register settings. One phase runs with
  // no idling on either side.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      load_regs(pick_level(), pick_level(), pick_level(), pick_level(), pick_level(),
                pick_margin(), pick_margin());
      if (phase == 2) begin
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
      end
      run_phase(40, 230);
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
      drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    // A result word that turns up late, after everything was matched, still
    // counts against the run.
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> text_overlay_pixel_generator.f
rtl/tovg_pkg.sv
rtl/tovg_cell_store.sv
rtl/text_overlay_pixel_generator.sv
tb/tb_text_overlay_pixel_generator.sv
